// ===== hdl/idiv_pkg.sv =====
// ----------------------------------------------------------------------------
// idiv_pkg
// Shared types and constants for the 128-bit integer divider.
// ----------------------------------------------------------------------------
package idiv_pkg;

  // Operand and result width
  localparam int unsigned OPERAND_BITS = 128;
  localparam int unsigned HALF_BITS    = 64;
  // One quotient bit per step
  localparam int unsigned STEPS        = OPERAND_BITS;
  localparam int unsigned CNT_W        = $clog2(STEPS);

  // Operation select carried on the request sideband
  typedef enum logic [1:0] {
    CMD_UQUO = 2'd0,
    CMD_UREM = 2'd1,
    CMD_SQUO = 2'd2,
    CMD_SREM = 2'd3
  } idiv_cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX,
    ST_OUT
  } idiv_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture operands, start a new division
    logic step;  // produce one quotient bit
    logic fix;   // apply sign and zero-divisor rules, fill output register
  } idiv_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic last_step;  // current step produces the final quotient bit
  } idiv_sts_t;

endpackage

// ===== hdl/idiv_ctrl.sv =====
// ----------------------------------------------------------------------------
// idiv_ctrl
// Sequencer for the divider: accepts a request, runs the step loop and the
// sign fix-up, holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module idiv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  idiv_pkg::idiv_sts_t sts_i,
  output idiv_pkg::idiv_ctl_t ctl_o
);

  idiv_pkg::idiv_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idiv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      idiv_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = idiv_pkg::ST_RUN;
      end
      idiv_pkg::ST_RUN: begin
        if (sts_i.last_step) state_d = idiv_pkg::ST_FIX;
      end
      idiv_pkg::ST_FIX: begin
        state_d = idiv_pkg::ST_OUT;
      end
      idiv_pkg::ST_OUT: begin
        if (out_ready_i) state_d = idiv_pkg::ST_IDLE;
      end
      default: begin
        state_d = idiv_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctl_o       = '0;
    case (state_q)
      idiv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i;
      end
      idiv_pkg::ST_RUN: begin
        ctl_o.step = 1'b1;
      end
      idiv_pkg::ST_FIX: begin
        ctl_o.fix = 1'b1;
      end
      idiv_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/idiv_dp.sv =====
// ----------------------------------------------------------------------------
// idiv_dp
// Datapath for the divider: magnitude capture, restoring shift-subtract
// loop with one quotient bit per step, sign fix-up and output register.
// ----------------------------------------------------------------------------
module idiv_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  idiv_pkg::idiv_ctl_t                 ctl_i,
  output idiv_pkg::idiv_sts_t                 sts_o,
  input  logic [1:0]                          command_i,
  input  logic [idiv_pkg::OPERAND_BITS-1:0]   dividend_i,
  input  logic [idiv_pkg::OPERAND_BITS-1:0]   divisor_i,
  output logic [idiv_pkg::OPERAND_BITS-1:0]   result_o
);

  localparam int unsigned W = idiv_pkg::OPERAND_BITS;

  logic [W-1:0]                 rem_q, rem_d;
  logic [W-1:0]                 quo_q, quo_d;   // dividend shifts out, quotient in
  logic [W-1:0]                 div_q, div_d;
  logic [W-1:0]                 res_q, res_d;
  logic [idiv_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         neg_quo_q, neg_quo_d;
  logic                         neg_rem_q, neg_rem_d;
  logic                         want_rem_q, want_rem_d;
  logic                         div_zero_q, div_zero_d;

  logic                         is_signed;
  logic                         a_neg, b_neg;
  logic [W+1:0]                 trial;
  logic [W:0]                   rem_shift;
  logic [W-1:0]                 pick;

  // Decode the operation
  assign is_signed = (command_i == idiv_pkg::CMD_SQUO) || (command_i == idiv_pkg::CMD_SREM);
  assign a_neg     = is_signed && dividend_i[W-1];
  assign b_neg     = is_signed && divisor_i[W-1];

  // Trial subtraction of one step; the shifted remainder needs one extra bit
  assign rem_shift = {rem_q, quo_q[W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, div_q};

  // Select the requested value before the sign fix
  assign pick = want_rem_q ? rem_q : quo_q;

  always_comb begin
    rem_d      = rem_q;
    quo_d      = quo_q;
    div_d      = div_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    neg_quo_d  = neg_quo_q;
    neg_rem_d  = neg_rem_q;
    want_rem_d = want_rem_q;
    div_zero_d = div_zero_q;
    if (ctl_i.load) begin
      // Capture magnitudes and sign rules
      rem_d      = '0;
      quo_d      = a_neg ? (~dividend_i + W'(1)) : dividend_i;
      div_d      = b_neg ? (~divisor_i + W'(1)) : divisor_i;
      cnt_d      = '0;
      neg_quo_d  = a_neg ^ b_neg;
      neg_rem_d  = a_neg;
      want_rem_d = (command_i == idiv_pkg::CMD_UREM) || (command_i == idiv_pkg::CMD_SREM);
      div_zero_d = (divisor_i == '0);
    end else if (ctl_i.step) begin
      // Keep the difference only when it does not go negative
      if (!trial[W+1]) begin
        rem_d = trial[W-1:0];
      end else begin
        rem_d = rem_shift[W-1:0];
      end
      quo_d = {quo_q[W-2:0], ~trial[W+1]};
      cnt_d = cnt_q + idiv_pkg::CNT_W'(1);
    end else if (ctl_i.fix) begin
      // Zero divisor gives zero; otherwise apply the sign
      if (div_zero_q) begin
        res_d = '0;
      end else if (want_rem_q ? neg_rem_q : neg_quo_q) begin
        res_d = ~pick + W'(1);
      end else begin
        res_d = pick;
      end
    end
  end

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    div_q      <= div_d;
    res_q      <= res_d;
    neg_quo_q  <= neg_quo_d;
    neg_rem_q  <= neg_rem_d;
    want_rem_q <= want_rem_d;
    div_zero_q <= div_zero_d;
  end

  assign sts_o.last_step = (cnt_q == idiv_pkg::CNT_W'(idiv_pkg::STEPS - 1));
  assign result_o        = res_q;

endmodule

// ===== hdl/int128_divider_top.sv =====
// ----------------------------------------------------------------------------
// int128_divider_top
// 128-bit integer divider with unsigned/signed quotient and remainder.
//
// Usage:
//   Requests enter on the s_axis channel: tdata carries the dividend and
//   divisor, tuser the operation (unsigned quotient, unsigned remainder,
//   signed quotient, signed remainder). Results leave on m_axis as one
//   128-bit word. Division by zero returns zero; a signed quotient is
//   negated when the operand signs differ, a signed remainder follows the
//   dividend sign, and the most negative value divided by -1 wraps.
//   One request is processed at a time: s_axis_tready is high only while
//   the block is idle. After acceptance the shift-subtract loop produces one
//   quotient bit per cycle through one 130-bit subtractor, then a sign
//   fix-up step fills the output register and the result is valid. A new
//   request is taken only once the block is idle again. If the receiver
//   stalls, the result is held in the output register and no new request is
//   taken until it is consumed. Reset returns the controller to idle and
//   drops any request in flight.
// ----------------------------------------------------------------------------
module int128_divider_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // dividend_lo[63:0], dividend_hi[127:64], divisor_lo[191:128], divisor_hi[255:192]
  input  logic [255:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // result_lo[63:0], result_hi[127:64]
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready
);

  idiv_pkg::idiv_ctl_t ctl;
  idiv_pkg::idiv_sts_t sts;

  // Sequencer
  idiv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Datapath
  idiv_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .command_i  (s_axis_tuser),
    .dividend_i (s_axis_tdata[127:0]),
    .divisor_i  (s_axis_tdata[255:128]),
    .result_o   (m_axis_tdata)
  );

endmodule
